// ===== hw/rtl/slcur_pkg.sv =====
// slcur_pkg: shared types and codes for the sorted list with cursor.
// Holds the command and response item structs and the command and status codes.
// No dependencies.
`timescale 1ns / 1ps

package slcur_pkg;

	localparam int VALUE_W = 32;
	localparam int COUNT_OUT_W = 7;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_FIRST  = 2'd1;
	localparam logic [1:0] CMD_NEXT   = 2'd2;
	localparam logic [1:0] CMD_REMOVE = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_END   = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_NOCUR = 2'd3;

	typedef struct packed {
		logic [1:0]                command;
		logic signed [VALUE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]                status;
		logic signed [VALUE_W-1:0] item_value;
		logic [COUNT_OUT_W-1:0]    entry_count;
	} rsp_t;

endpackage

// ===== hw/rtl/slcur_ram.sv =====
// slcur_ram: generic single-clock RAM, one write port and one read port.
// Read data is registered. No dependencies.
`timescale 1ns / 1ps

module slcur_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/sorted_list_with_cursor.sv =====
// sorted_list_with_cursor: bounded ordered list of signed values with one cursor.
// Entries live in one slcur_ram; a sequencer walks them one per cycle.
// Depends on slcur_pkg and slcur_ram.
//
//   channel  dir  handshake              payload
//   cmd      in   cmd_valid / cmd_ready  slcur_pkg::cmd_t  (command, value)
//   rsp      out  rsp_valid / rsp_ready  slcur_pkg::rsp_t  (status, item_value, entry_count)
//   cfg      in   cfg_valid / cfg_ready  cfg_data = sort_mode
//
// Insert walks the list once from the front through the RAM port. Remove shifts the tail
// down. First and next read one entry; rejected items go straight to the response. Reset
// clears count and cursor; the RAM needs no clearing pass. A stalled rsp holds the finished
// item; the next item is sequenced meanwhile and waits only to hand over its result.
`timescale 1ns / 1ps

module sorted_list_with_cursor #(
	parameter int CAPACITY = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  slcur_pkg::cmd_t cmd,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output slcur_pkg::rsp_t rsp,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic            cfg_data
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int VW = slcur_pkg::VALUE_W;
	localparam int OW = slcur_pkg::COUNT_OUT_W;

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_READ      = 3'd1;
	localparam logic [2:0] S_INS       = 3'd2;
	localparam logic [2:0] S_REM_HEAD  = 3'd3;
	localparam logic [2:0] S_REM_SHIFT = 3'd4;
	localparam logic [2:0] S_FIN       = 3'd5;

	logic [2:0]    state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] cursor_q;
	logic          cursor_valid_q;
	logic          removable_q;
	logic          sort_mode_q;
	logic [CW-1:0] idx_q;
	logic          found_q;
	logic [CW-1:0] pos_q;
	logic [VW-1:0] carry_q;
	logic [VW-1:0] val_q;
	logic [1:0]    pend_status_q;
	logic [VW-1:0] pend_item_q;
	logic          rsp_valid_q;
	slcur_pkg::rsp_t rsp_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [VW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [VW-1:0] ram_rdata;

	logic          accept;
	logic          is_full;
	logic          greater;
	logic          ins_hit;
	logic          ins_last;
	logic [CW-1:0] idx_p1;
	logic [CW-1:0] idx_p2;
	logic [CW-1:0] cursor_m1;
	logic [CW-1:0] pos_fin;
	logic [CW+OW-1:0] count_ext;

	slcur_ram #(
		.WIDTH(VW),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign cmd_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign accept    = cmd_valid && cmd_ready;
	assign is_full   = (count_q == CW'(CAPACITY));
	assign greater   = ($signed(ram_rdata) > $signed(val_q));
	assign ins_last  = (idx_q == count_q);
	assign ins_hit   = !found_q && !ins_last && (!sort_mode_q || greater);
	assign idx_p1    = idx_q + CW'(1);
	assign idx_p2    = idx_q + CW'(2);
	assign cursor_m1 = cursor_q - CW'(1);
	assign pos_fin   = found_q ? pos_q : idx_q;
	assign count_ext = {{OW{1'b0}}, count_q};

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = found_q ? carry_q : val_q;
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				ram_re = accept;
				unique case (cmd.command)
					slcur_pkg::CMD_NEXT:   ram_raddr = cursor_q[AW-1:0];
					slcur_pkg::CMD_REMOVE: ram_raddr = cursor_m1[AW-1:0];
					slcur_pkg::CMD_INSERT,
					slcur_pkg::CMD_FIRST:  ram_raddr = '0;
				endcase
			end
			S_INS: begin
				ram_we    = found_q || ins_hit || ins_last;
				ram_re    = !ins_last;
				ram_raddr = idx_p1[AW-1:0];
			end
			S_REM_HEAD: begin
				ram_re    = 1'b1;
				ram_raddr = idx_p1[AW-1:0];
			end
			S_REM_SHIFT: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
				ram_re    = 1'b1;
				ram_raddr = idx_p2[AW-1:0];
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			count_q        <= '0;
			cursor_q       <= '0;
			cursor_valid_q <= 1'b0;
			removable_q    <= 1'b0;
			sort_mode_q    <= 1'b0;
			rsp_valid_q    <= 1'b0;
			idx_q          <= '0;
			found_q        <= 1'b0;
		end else begin
			if (cfg_valid) begin
				sort_mode_q <= cfg_data;
			end
			if (state_q == S_FIN && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q   <= (cmd.command == slcur_pkg::CMD_REMOVE) ? cursor_m1 : '0;
						found_q <= 1'b0;
						unique case (cmd.command)
							slcur_pkg::CMD_INSERT: begin
								if (is_full) begin
									state_q <= S_FIN;
								end else begin
									state_q <= S_INS;
								end
							end
							slcur_pkg::CMD_FIRST: begin
								if (count_q == '0) begin
									state_q <= S_FIN;
								end else begin
									cursor_q       <= CW'(1);
									cursor_valid_q <= 1'b1;
									removable_q    <= 1'b1;
									state_q        <= S_READ;
								end
							end
							slcur_pkg::CMD_NEXT: begin
								if (!cursor_valid_q || cursor_q >= count_q) begin
									state_q <= S_FIN;
								end else begin
									cursor_q    <= cursor_q + CW'(1);
									removable_q <= 1'b1;
									state_q     <= S_READ;
								end
							end
							slcur_pkg::CMD_REMOVE: begin
								if (!cursor_valid_q || !removable_q || cursor_q == '0 ||
										cursor_q > count_q) begin
									state_q <= S_FIN;
								end else begin
									state_q <= S_REM_HEAD;
								end
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= S_FIN;
				end
				S_INS: begin
					if (ins_hit) begin
						found_q <= 1'b1;
					end
					if (ins_last) begin
						count_q <= count_q + CW'(1);
						if (cursor_q != '0 && pos_fin < cursor_q) begin
							cursor_q <= cursor_q + CW'(1);
						end
						state_q <= S_FIN;
					end else begin
						idx_q <= idx_p1;
					end
				end
				S_REM_HEAD: begin
					if (idx_p1 < count_q) begin
						state_q <= S_REM_SHIFT;
					end else begin
						count_q     <= count_q - CW'(1);
						cursor_q    <= cursor_m1;
						removable_q <= 1'b0;
						state_q     <= S_FIN;
					end
				end
				S_REM_SHIFT: begin
					if (idx_p2 < count_q) begin
						idx_q <= idx_p1;
					end else begin
						count_q     <= count_q - CW'(1);
						cursor_q    <= cursor_m1;
						removable_q <= 1'b0;
						state_q     <= S_FIN;
					end
				end
				S_FIN: begin
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload path: no reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					val_q       <= cmd.value;
					pend_item_q <= '0;
					unique case (cmd.command)
						slcur_pkg::CMD_INSERT: begin
							pend_status_q <= is_full ? slcur_pkg::ST_FULL : slcur_pkg::ST_OK;
						end
						slcur_pkg::CMD_FIRST: begin
							pend_status_q <= (count_q == '0) ? slcur_pkg::ST_END
								: slcur_pkg::ST_OK;
						end
						slcur_pkg::CMD_NEXT: begin
							if (!cursor_valid_q) begin
								pend_status_q <= slcur_pkg::ST_NOCUR;
							end else if (cursor_q >= count_q) begin
								pend_status_q <= slcur_pkg::ST_END;
							end else begin
								pend_status_q <= slcur_pkg::ST_OK;
							end
						end
						slcur_pkg::CMD_REMOVE: begin
							if (!cursor_valid_q || !removable_q || cursor_q == '0 ||
									cursor_q > count_q) begin
								pend_status_q <= slcur_pkg::ST_NOCUR;
							end else begin
								pend_status_q <= slcur_pkg::ST_OK;
							end
						end
					endcase
				end
			end
			S_READ, S_REM_HEAD: begin
				pend_item_q <= ram_rdata;
			end
			S_INS: begin
				carry_q <= ram_rdata;
				if (ins_hit) begin
					pos_q <= idx_q;
				end
			end
			S_FIN: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_q.status      <= pend_status_q;
					rsp_q.item_value  <= pend_item_q;
					rsp_q.entry_count <= count_ext[OW-1:0];
				end
			end
			default: begin
				carry_q <= carry_q;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= count_q)
		else $error("cursor beyond list end");

	a_removable_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		removable_q |-> cursor_valid_q)
		else $error("removable without valid cursor");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ({1'b0, ram_waddr} <= (AW + 1)'(count_q)))
		else $error("entry write beyond list end");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_FIN) |-> !ram_we)
		else $error("entry write outside a list walk");
`endif

endmodule
